@@ rtl/obot_pkg.sv @@
// shared widths, payload structs and helpers for the oriented box overlap test
package obot_pkg;

   localparam int COORD_WIDTH    = 24;
   localparam int TRIG_FRAC_BITS = 14;
   localparam int TRIG_WIDTH     = 16;
   localparam int SIZE_WIDTH     = 16;

   localparam int DELTA_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = DELTA_WIDTH + TRIG_WIDTH;
   localparam int PROJ_WIDTH  = PROD_WIDTH + 1;
   localparam int TPROD_WIDTH = 2 * TRIG_WIDTH;
   localparam int TDOT_WIDTH  = TPROD_WIDTH + 1;
   localparam int SPROD_WIDTH = SIZE_WIDTH + TDOT_WIDTH;
   localparam int RAD_WIDTH   = SPROD_WIDTH + 2;
   localparam int EXT_SHIFT   = 2 * TRIG_FRAC_BITS;
   localparam int LIM_SHIFT   = TRIG_FRAC_BITS + 1;

   typedef struct packed {
      logic signed [TRIG_WIDTH-1:0]  sine;
      logic signed [TRIG_WIDTH-1:0]  cosine;
      logic        [SIZE_WIDTH-1:0]  wid;
      logic        [SIZE_WIDTH-1:0]  len;
      logic signed [COORD_WIDTH-1:0] cy;
      logic signed [COORD_WIDTH-1:0] cx;
   } box_type;

   // box a in the low bits, center x lowest
   typedef struct packed {
      box_type b;
      box_type a;
   } pair_type;

   localparam int PAIR_BITS      = $bits(pair_type);
   localparam int REQ_DATA_WIDTH = ((PAIR_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = 8;

   typedef struct packed {
      logic        [TDOT_WIDTH-1:0] mc;
      logic        [TDOT_WIDTH-1:0] ms;
      logic signed [PROD_WIDTH-1:0] x_ac;
      logic signed [PROD_WIDTH-1:0] y_as;
      logic signed [PROD_WIDTH-1:0] x_as;
      logic signed [PROD_WIDTH-1:0] y_ac;
      logic signed [PROD_WIDTH-1:0] x_bc;
      logic signed [PROD_WIDTH-1:0] y_bs;
      logic signed [PROD_WIDTH-1:0] x_bs;
      logic signed [PROD_WIDTH-1:0] y_bc;
      logic        [SIZE_WIDTH-1:0] al;
      logic        [SIZE_WIDTH-1:0] aw;
      logic        [SIZE_WIDTH-1:0] bl;
      logic        [SIZE_WIDTH-1:0] bw;
   } proj_type;

   typedef struct packed {
      logic [3:0][PROJ_WIDTH-1:0] p;
      logic [3:0][RAD_WIDTH-1:0]  r;
   } radius_type;

   function automatic logic [TDOT_WIDTH-1:0] tdot_mag(input logic signed [TDOT_WIDTH-1:0] v);
      return v[TDOT_WIDTH-1] ? TDOT_WIDTH'(-v) : TDOT_WIDTH'(v);
   endfunction

   function automatic logic [PROJ_WIDTH-1:0] proj_mag(input logic signed [PROJ_WIDTH-1:0] v);
      return v[PROJ_WIDTH-1] ? PROJ_WIDTH'(-v) : PROJ_WIDTH'(v);
   endfunction

endpackage

@@ rtl/obot_project.sv @@
// stages 1-2: center deltas, heading cross terms and center projections
module obot_project (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  obot_pkg::pair_type  in_pair,
   output logic                out_valid,
   input  logic                out_ready,
   output obot_pkg::proj_type  out_proj
);

   typedef struct packed {
      logic signed [obot_pkg::DELTA_WIDTH-1:0] dx;
      logic signed [obot_pkg::DELTA_WIDTH-1:0] dy;
      logic signed [obot_pkg::TPROD_WIDTH-1:0] t_cc;
      logic signed [obot_pkg::TPROD_WIDTH-1:0] t_ss;
      logic signed [obot_pkg::TPROD_WIDTH-1:0] t_sc;
      logic signed [obot_pkg::TPROD_WIDTH-1:0] t_cs;
      logic signed [obot_pkg::TRIG_WIDTH-1:0]  a_cos;
      logic signed [obot_pkg::TRIG_WIDTH-1:0]  a_sin;
      logic signed [obot_pkg::TRIG_WIDTH-1:0]  b_cos;
      logic signed [obot_pkg::TRIG_WIDTH-1:0]  b_sin;
      logic        [obot_pkg::SIZE_WIDTH-1:0]  al;
      logic        [obot_pkg::SIZE_WIDTH-1:0]  aw;
      logic        [obot_pkg::SIZE_WIDTH-1:0]  bl;
      logic        [obot_pkg::SIZE_WIDTH-1:0]  bw;
   } front_type;

   localparam int DW = obot_pkg::DELTA_WIDTH;
   localparam int TW = obot_pkg::TPROD_WIDTH;
   localparam int DTW = obot_pkg::TDOT_WIDTH;
   localparam int PW = obot_pkg::PROD_WIDTH;

   logic               s1_valid_ff;
   logic               s2_valid_ff;
   logic               s1_en;
   logic               s2_en;
   front_type          s1_in;
   front_type          s1_ff;
   obot_pkg::proj_type s2_in;
   obot_pkg::proj_type s2_ff;

   assign s2_en    = !s2_valid_ff || out_ready;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;

   always_comb begin
      s1_in.dx    = DW'($signed(in_pair.b.cx)) - DW'($signed(in_pair.a.cx));
      s1_in.dy    = DW'($signed(in_pair.b.cy)) - DW'($signed(in_pair.a.cy));
      s1_in.t_cc  = TW'($signed(in_pair.a.cosine)) * TW'($signed(in_pair.b.cosine));
      s1_in.t_ss  = TW'($signed(in_pair.a.sine)) * TW'($signed(in_pair.b.sine));
      s1_in.t_sc  = TW'($signed(in_pair.a.sine)) * TW'($signed(in_pair.b.cosine));
      s1_in.t_cs  = TW'($signed(in_pair.a.cosine)) * TW'($signed(in_pair.b.sine));
      s1_in.a_cos = in_pair.a.cosine;
      s1_in.a_sin = in_pair.a.sine;
      s1_in.b_cos = in_pair.b.cosine;
      s1_in.b_sin = in_pair.b.sine;
      s1_in.al    = in_pair.a.len;
      s1_in.aw    = in_pair.a.wid;
      s1_in.bl    = in_pair.b.len;
      s1_in.bw    = in_pair.b.wid;
   end

   // the two heading cross terms serve all four axes, only their magnitudes matter
   always_comb begin
      s2_in.mc   = obot_pkg::tdot_mag(DTW'($signed(s1_ff.t_cc)) + DTW'($signed(s1_ff.t_ss)));
      s2_in.ms   = obot_pkg::tdot_mag(DTW'($signed(s1_ff.t_sc)) - DTW'($signed(s1_ff.t_cs)));
      s2_in.x_ac = PW'($signed(s1_ff.dx)) * PW'($signed(s1_ff.a_cos));
      s2_in.y_as = PW'($signed(s1_ff.dy)) * PW'($signed(s1_ff.a_sin));
      s2_in.x_as = PW'($signed(s1_ff.dx)) * PW'($signed(s1_ff.a_sin));
      s2_in.y_ac = PW'($signed(s1_ff.dy)) * PW'($signed(s1_ff.a_cos));
      s2_in.x_bc = PW'($signed(s1_ff.dx)) * PW'($signed(s1_ff.b_cos));
      s2_in.y_bs = PW'($signed(s1_ff.dy)) * PW'($signed(s1_ff.b_sin));
      s2_in.x_bs = PW'($signed(s1_ff.dx)) * PW'($signed(s1_ff.b_sin));
      s2_in.y_bc = PW'($signed(s1_ff.dy)) * PW'($signed(s1_ff.b_cos));
      s2_in.al   = s1_ff.al;
      s2_in.aw   = s1_ff.aw;
      s2_in.bl   = s1_ff.bl;
      s2_in.bw   = s1_ff.bw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && in_valid) begin
         s1_ff <= s1_in;
      end
      if (s2_en && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_proj  = s2_ff;

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> in_ready) else $error("empty first stage refuses a word");

endmodule

@@ rtl/obot_radius.sv @@
// stages 3-4: projection magnitudes and the projected half-extent sums
module obot_radius (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  obot_pkg::proj_type   in_proj,
   output logic                 out_valid,
   input  logic                 out_ready,
   output obot_pkg::radius_type out_rad
);

   localparam int PJW = obot_pkg::PROJ_WIDTH;
   localparam int SW  = obot_pkg::SPROD_WIDTH;
   localparam int RW  = obot_pkg::RAD_WIDTH;

   typedef struct packed {
      logic [3:0][PJW-1:0]                p;
      logic [SW-1:0]                      bl_mc;
      logic [SW-1:0]                      bw_ms;
      logic [SW-1:0]                      bl_ms;
      logic [SW-1:0]                      bw_mc;
      logic [SW-1:0]                      al_mc;
      logic [SW-1:0]                      aw_ms;
      logic [SW-1:0]                      al_ms;
      logic [SW-1:0]                      aw_mc;
      logic [obot_pkg::SIZE_WIDTH-1:0]    al;
      logic [obot_pkg::SIZE_WIDTH-1:0]    aw;
      logic [obot_pkg::SIZE_WIDTH-1:0]    bl;
      logic [obot_pkg::SIZE_WIDTH-1:0]    bw;
   } extent_type;

   logic                 s3_valid_ff;
   logic                 s4_valid_ff;
   logic                 s3_en;
   logic                 s4_en;
   extent_type           s3_in;
   extent_type           s3_ff;
   obot_pkg::radius_type s4_in;
   obot_pkg::radius_type s4_ff;

   assign s4_en    = !s4_valid_ff || out_ready;
   assign s3_en    = !s3_valid_ff || s4_en;
   assign in_ready = s3_en;

   always_comb begin
      s3_in.p[0]  = obot_pkg::proj_mag(PJW'($signed(in_proj.x_ac)) + PJW'($signed(in_proj.y_as)));
      s3_in.p[1]  = obot_pkg::proj_mag(PJW'($signed(in_proj.x_as)) - PJW'($signed(in_proj.y_ac)));
      s3_in.p[2]  = obot_pkg::proj_mag(PJW'($signed(in_proj.x_bc)) + PJW'($signed(in_proj.y_bs)));
      s3_in.p[3]  = obot_pkg::proj_mag(PJW'($signed(in_proj.x_bs)) - PJW'($signed(in_proj.y_bc)));
      s3_in.bl_mc = SW'(in_proj.bl) * SW'(in_proj.mc);
      s3_in.bw_ms = SW'(in_proj.bw) * SW'(in_proj.ms);
      s3_in.bl_ms = SW'(in_proj.bl) * SW'(in_proj.ms);
      s3_in.bw_mc = SW'(in_proj.bw) * SW'(in_proj.mc);
      s3_in.al_mc = SW'(in_proj.al) * SW'(in_proj.mc);
      s3_in.aw_ms = SW'(in_proj.aw) * SW'(in_proj.ms);
      s3_in.al_ms = SW'(in_proj.al) * SW'(in_proj.ms);
      s3_in.aw_mc = SW'(in_proj.aw) * SW'(in_proj.mc);
      s3_in.al    = in_proj.al;
      s3_in.aw    = in_proj.aw;
      s3_in.bl    = in_proj.bl;
      s3_in.bw    = in_proj.bw;
   end

   // own extent scaled by trig unit squared, other box projected through cross terms
   always_comb begin
      s4_in.p    = s3_ff.p;
      s4_in.r[0] = RW'(s3_ff.bl_mc) + RW'(s3_ff.bw_ms) + (RW'(s3_ff.al) << obot_pkg::EXT_SHIFT);
      s4_in.r[1] = RW'(s3_ff.bl_ms) + RW'(s3_ff.bw_mc) + (RW'(s3_ff.aw) << obot_pkg::EXT_SHIFT);
      s4_in.r[2] = RW'(s3_ff.al_mc) + RW'(s3_ff.aw_ms) + (RW'(s3_ff.bl) << obot_pkg::EXT_SHIFT);
      s4_in.r[3] = RW'(s3_ff.al_ms) + RW'(s3_ff.aw_mc) + (RW'(s3_ff.bw) << obot_pkg::EXT_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_en) begin
            s3_valid_ff <= in_valid;
         end
         if (s4_en) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en && in_valid) begin
         s3_ff <= s3_in;
      end
      if (s4_en && s3_valid_ff) begin
         s4_ff <= s4_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_rad   = s4_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !out_ready |=> s4_valid_ff && $stable(s4_ff))
      else $error("stalled radius word changed");

endmodule

@@ rtl/obot_decide.sv @@
// stage 5: per-axis compare and the registered overlap flag
module obot_decide (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  obot_pkg::radius_type in_rad,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_hit
);

   localparam int RW = obot_pkg::RAD_WIDTH;

   logic       s5_valid_ff;
   logic       s5_en;
   logic [3:0] axis_ok;
   logic       hit_in;
   logic       hit_ff;

   assign s5_en    = !s5_valid_ff || out_ready;
   assign in_ready = s5_en;

   // touching counts as overlap, so the compare is inclusive
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         axis_ok[k] = {{(RW - obot_pkg::PROJ_WIDTH){1'b0}}, in_rad.p[k]}
                      <= (in_rad.r[k] >> obot_pkg::LIM_SHIFT);
      end
      hit_in = &axis_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (s5_en) begin
         s5_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_en && in_valid) begin
         hit_ff <= hit_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_hit   = hit_ff;

   a_zero_proj_hits: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready && in_rad.p == '0 |=> out_valid && out_hit)
      else $error("zero center projections must report overlap");

endmodule

@@ rtl/oriented_box_overlap_test_top.sv @@
// top level of the oriented box overlap test: stream ports and the stage chain
// an accepted req word is registered in the project, radius and decide stages in turn before rsp_tvalid
// throughput: one box pair per cycle while rsp_tready is high; each stage takes a word when it is empty
//   or its successor advances, so a stall only fills the bubbles ahead of it
// reset: synchronous, clears the five stage valid bits; payload registers hold
module oriented_box_overlap_test_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a_center_x, a_center_y, a_length, a_width, a_cosine, a_sine,
   // b_center_x, b_center_y, b_length, b_width, b_cosine, b_sine
   input  logic [obot_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // boxes_overlap, then zero fill
   output logic [obot_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   obot_pkg::pair_type   pair;
   obot_pkg::proj_type   proj;
   obot_pkg::radius_type rad;
   logic                 proj_valid;
   logic                 proj_ready;
   logic                 rad_valid;
   logic                 rad_ready;
   logic                 hit;

   assign pair = obot_pkg::pair_type'(req_tdata[obot_pkg::PAIR_BITS-1:0]);

   obot_project u_project (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pair   (pair),
      .out_valid (proj_valid),
      .out_ready (proj_ready),
      .out_proj  (proj)
   );

   obot_radius u_radius (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proj_valid),
      .in_ready  (proj_ready),
      .in_proj   (proj),
      .out_valid (rad_valid),
      .out_ready (rad_ready),
      .out_rad   (rad)
   );

   obot_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rad_valid),
      .in_ready  (rad_ready),
      .in_rad    (rad),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (hit)
   );

   assign rsp_tdata = {{(obot_pkg::RSP_DATA_WIDTH - 1){1'b0}}, hit};

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("result word present right after reset");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[obot_pkg::RSP_DATA_WIDTH-1:1] == '0)
      else $error("rsp word fill bits not zero");

endmodule
